@@ rtl/core/mrr_pkg.sv @@
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared widths and codes for the matrix ring rotation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mrr_pkg;

  localparam int CoordW  = 5;
  localparam int CountW  = 6;
  localparam int LenW    = 8;
  localparam int RingW   = 5;
  localparam int NumRing = 1 << RingW;
  localparam int RotW    = 32;
  localparam int PortW   = 32;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgRowCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgColCount = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRotCount = 2'd2;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncRead  = 1'b1;

endpackage

`default_nettype wire

@@ rtl/core/mrr_residue.sv @@
// ----------------------------------------------------------------------------
// mrr_residue
// Per-ring residue table: rotation count modulo each ring length, built by a
// bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mrr_residue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mrr_pkg::CountW-1:0] row_cnt_i,
  input  logic [mrr_pkg::CountW-1:0] col_cnt_i,
  input  logic [mrr_pkg::RotW-1:0]   rot_i,
  input  logic [mrr_pkg::RingW-1:0]  ring_i,
  output logic                       busy_o,
  output logic [mrr_pkg::LenW-1:0]   residue_o
);
  import mrr_pkg::*;

  localparam logic [RingW-1:0] LastRing = RingW'(NumRing - 1);
  localparam logic [4:0]       LastBit  = 5'(RotW - 1);

  logic             busy_q, busy_d;
  logic [RingW-1:0] ring_q, ring_d;
  logic [4:0]       bit_q, bit_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic [LenW-1:0]  tbl_q [NumRing];
  logic [LenW-1:0]  residue_q;
  logic             tbl_we;

  logic [CountW-1:0] two_d;
  logic              ring_ok;
  logic [CountW-1:0] hs, ws;
  logic [LenW-1:0]   len;
  logic [LenW:0]     rem_ext;
  logic [LenW-1:0]   rem_n;

  always_comb begin
    two_d   = {ring_q, 1'b0};
    ring_ok = ({1'b0, row_cnt_i} > ({1'b0, two_d} + 7'd1)) &&
              ({1'b0, col_cnt_i} > ({1'b0, two_d} + 7'd1));
    hs      = row_cnt_i - two_d - 6'd1;
    ws      = col_cnt_i - two_d - 6'd1;
    len     = {LenW'(hs) + LenW'(ws)} << 1;
    rem_ext = {rem_q, rot_i[bit_q]};
    if (rem_ext >= {1'b0, len}) begin
      rem_n = LenW'(rem_ext - {1'b0, len});
    end else begin
      rem_n = LenW'(rem_ext);
    end
  end

  always_comb begin
    busy_d = busy_q;
    ring_d = ring_q;
    bit_d  = bit_q;
    rem_d  = rem_q;
    tbl_we = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      ring_d = '0;
      bit_d  = LastBit;
      rem_d  = '0;
    end else if (busy_q) begin
      if (!ring_ok) begin
        busy_d = 1'b0;
      end else if (bit_q == '0) begin
        tbl_we = 1'b1;
        rem_d  = '0;
        bit_d  = LastBit;
        if (ring_q == LastRing) begin
          busy_d = 1'b0;
        end else begin
          ring_d = ring_q + 1'b1;
        end
      end else begin
        rem_d = rem_n;
        bit_d = bit_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      ring_q <= '0;
      bit_q  <= LastBit;
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      ring_q <= ring_d;
      bit_q  <= bit_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_q[ring_q] <= rem_n;
    end
    residue_q <= tbl_q[ring_i];
  end

  assign busy_o    = busy_q;
  assign residue_o = residue_q;

endmodule

`default_nettype wire

@@ rtl/core/matrix_ring_rotation_unit.sv @@
// ----------------------------------------------------------------------------
// matrix_ring_rotation_unit
// Matrix store whose reads see every concentric ring rotated by a set count.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A write is registered on acceptance
// and then stored. A read passes these steps to reach the output register:
// ring geometry, residue add with one conditional subtract, source coordinate
// and store read, data capture. Out-of-range beats return from geometry.
// The element store is a single synchronous RAM of MAX_DIM*MAX_DIM entries.
// After reset and after every configuration write, a bit-serial divider
// rebuilds the per-ring table of rotation_count modulo ring length, for each
// ring with more than one row and column, while in_stall_o is held high.
`default_nettype none

module matrix_ring_rotation_unit #(
  parameter int MAX_DIM    = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mrr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mrr_pkg::RotW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [mrr_pkg::CoordW-1:0]  row_i,
  input  logic [mrr_pkg::CoordW-1:0]  col_i,
  input  logic [mrr_pkg::PortW-1:0]   write_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mrr_pkg::PortW-1:0]   read_value_o,
  output logic                        bad_position_o
);
  import mrr_pkg::*;

  localparam int Depth  = MAX_DIM * MAX_DIM;
  localparam int AddrW  = $clog2(Depth);
  localparam int DimCap = (MAX_DIM > 63) ? 63 : MAX_DIM;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StGeom = 3'd1;
  localparam logic [2:0] StRot  = 3'd2;
  localparam logic [2:0] StMap  = 3'd3;
  localparam logic [2:0] StData = 3'd4;

  logic [CountW-1:0] row_cnt_q, col_cnt_q;
  logic [RotW-1:0]   rot_q;
  logic [CountW-1:0] nr, nc;

  logic [2:0] state_q, state_d;

  logic              func_q;
  logic [CoordW-1:0] r_q, c_q;
  logic [PortW-1:0]  wv_q;

  logic [CountW-1:0] d_q, bottom_q, right_q, hs_q, ws_q;
  logic [LenW-1:0]   pos_q, len_q, np_q, np_d;
  logic              deg_q;

  logic [DATA_WIDTH-1:0] mem_q [Depth];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic                  mem_we, mem_re;
  logic [AddrW-1:0]      waddr, raddr;

  logic             out_valid_q, out_valid_d;
  logic [PortW-1:0] rv_q;
  logic             bad_o_q;
  logic             emit, emit_bad, out_free;

  logic             in_acc;
  logic             res_busy;
  logic [LenW-1:0]  residue;

  // geometry
  logic              bad;
  logic [CountW-1:0] r6, c6, nr_m1, nc_m1, rr, cc, d6, two_d, h, w;
  logic [CountW-1:0] bottom, right, hs, ws;
  logic              deg;
  logic [LenW-1:0]   sum, len, pos;
  logic [LenW:0]     np_sum;
  logic [LenW-1:0]   b_a, b_b, b_c;
  logic [CountW-1:0] sr, sc;

  always_comb begin
    nr = row_cnt_q;
    nc = col_cnt_q;
    if (row_cnt_q == '0) begin
      nr = CountW'(1);
    end else if (int'(row_cnt_q) > MAX_DIM) begin
      nr = CountW'(DimCap);
    end
    if (col_cnt_q == '0) begin
      nc = CountW'(1);
    end else if (int'(col_cnt_q) > MAX_DIM) begin
      nc = CountW'(DimCap);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= CountW'(2);
      col_cnt_q <= CountW'(2);
      rot_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRowCount: row_cnt_q <= cfg_wdata_i[CountW-1:0];
        CfgColCount: col_cnt_q <= cfg_wdata_i[CountW-1:0];
        CfgRotCount: rot_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mrr_residue u_residue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cfg_we_i),
    .row_cnt_i (nr),
    .col_cnt_i (nc),
    .rot_i     (rot_q),
    .ring_i    (d6[RingW-1:0]),
    .busy_o    (res_busy),
    .residue_o (residue)
  );

  assign in_stall_o = (state_q != StIdle) || res_busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_i;
      r_q    <= row_i;
      c_q    <= col_i;
      wv_q   <= write_value_i;
    end
  end

  always_comb begin
    r6     = CountW'(r_q);
    c6     = CountW'(c_q);
    bad    = (r6 >= nr) || (c6 >= nc);
    nr_m1  = nr - 6'd1;
    nc_m1  = nc - 6'd1;
    rr     = nr_m1 - r6;
    cc     = nc_m1 - c6;
    d6     = (r6 < rr) ? r6 : rr;
    d6     = (c6 < d6) ? c6 : d6;
    d6     = (cc < d6) ? cc : d6;
    two_d  = {d6[RingW-1:0], 1'b0};
    h      = nr - two_d;
    w      = nc - two_d;
    deg    = (h <= 6'd1) || (w <= 6'd1);
    bottom = nr_m1 - d6;
    right  = nc_m1 - d6;
    hs     = h - 6'd1;
    ws     = w - 6'd1;
    sum    = LenW'(hs) + LenW'(ws);
    len    = sum << 1;
    priority if (r6 == d6) begin
      pos = LenW'(c6 - d6);
    end else if (r6 == bottom) begin
      pos = sum + LenW'(right - c6);
    end else if (c6 == d6) begin
      pos = (LenW'(ws) << 1) + LenW'(hs) + LenW'(bottom - r6);
    end else begin
      pos = LenW'(ws) + LenW'(r6 - d6);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StGeom) begin
      d_q      <= d6;
      bottom_q <= bottom;
      right_q  <= right;
      hs_q     <= hs;
      ws_q     <= ws;
      pos_q    <= pos;
      len_q    <= len;
      deg_q    <= deg;
    end
    if (state_q == StRot) begin
      np_q <= np_d;
    end
  end

  always_comb begin
    np_sum = {1'b0, pos_q} + {1'b0, residue};
    if (np_sum >= {1'b0, len_q}) begin
      np_d = LenW'(np_sum - {1'b0, len_q});
    end else begin
      np_d = LenW'(np_sum);
    end
  end

  always_comb begin
    b_a = LenW'(ws_q);
    b_b = LenW'(hs_q) + LenW'(ws_q);
    b_c = (LenW'(ws_q) << 1) + LenW'(hs_q);
    priority if (deg_q) begin
      sr = CountW'(r_q);
      sc = CountW'(c_q);
    end else if (np_q <= b_a) begin
      sr = d_q;
      sc = d_q + CountW'(np_q);
    end else if (np_q <= b_b) begin
      sr = d_q + CountW'(np_q - b_a);
      sc = right_q;
    end else if (np_q < b_c) begin
      sr = bottom_q;
      sc = right_q - CountW'(np_q - b_b);
    end else begin
      sr = bottom_q - CountW'(np_q - b_c);
      sc = d_q;
    end
    raddr = AddrW'(int'(sr) * MAX_DIM + int'(sc));
    waddr = AddrW'(int'(r_q) * MAX_DIM + int'(c_q));
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= DATA_WIDTH'(wv_q);
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    emit     = 1'b0;
    emit_bad = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StGeom;
        end
      end
      StGeom: begin
        if (bad) begin
          if (out_free) begin
            emit     = 1'b1;
            emit_bad = 1'b1;
            state_d  = StIdle;
          end
        end else if (func_q == FuncWrite) begin
          mem_we  = 1'b1;
          state_d = StIdle;
        end else begin
          state_d = StRot;
        end
      end
      StRot: begin
        state_d = StMap;
      end
      StMap: begin
        mem_re  = 1'b1;
        state_d = StData;
      end
      StData: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      rv_q    <= emit_bad ? '0 : PortW'(rdata_q);
      bad_o_q <= emit_bad;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_value_o   = rv_q;
  assign bad_position_o = bad_o_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_busy |-> in_stall_o)
    else $error("beat accepted while residue table rebuilds");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == StGeom)
    else $error("accepted beat did not enter geometry stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRot && !deg_q) |-> residue < len_q)
    else $error("ring residue not below ring length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMap && !deg_q) |-> np_q < len_q)
    else $error("rotated ring position out of range");

endmodule

`default_nettype wire
